/* rtl/hnti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hnti_pkg;

    localparam int NAME_W  = 8;
    localparam int INDEX_W = 16;
    localparam int HASH_W  = 32;
    localparam int POS_W   = 11;
    localparam int COUNT_W = 12;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic [HASH_W-1:0] MIX_RESET = 32'hcb03f267;

    // Values of insert_status.
    localparam logic STATUS_CLAIMED = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_CHECK,
        ST_REPORT
    } state_t;

    // Strobes from the sequencer to the slot store.
    typedef struct packed {
        logic rd_en;
        logic wr_owner_en;
        logic wr_hash_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/hnti_hash.sv */
`timescale 1ns / 1ps
`default_nettype none

module hnti_hash
    import hnti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [NAME_W-1:0] name_byte,
    input  wire logic              byte_present,
    input  wire logic              last_byte,
    input  wire logic              cfg_fire,
    input  wire logic [HASH_W-1:0] type_mix,
    output logic      [HASH_W-1:0] mixed_hash
);

    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;
    logic [HASH_W-1:0] type_mix_reg;
    logic [HASH_W-1:0] hash_upd;

    // h * 33 + byte, written as a shift and add.
    always_comb
    begin
        if (byte_present)
        begin
            hash_upd = (running_hash_reg << 5) + running_hash_reg
                       + {{(HASH_W-NAME_W){1'b0}}, name_byte};
        end
        else
        begin
            hash_upd = running_hash_reg;
        end
        mixed_hash = hash_upd ^ type_mix_reg;
        running_hash_next = running_hash_reg;
        if (in_fire)
        begin
            running_hash_next = last_byte ? HASH_SEED : hash_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= HASH_SEED;
            type_mix_reg     <= MIX_RESET;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            if (cfg_fire)
            begin
                type_mix_reg <= type_mix;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/hnti_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module hnti_slot_mem
    import hnti_pkg::*;
#(
    parameter int SLOT_W = 11
)
(
    input  wire logic               clk,
    input  wire mem_ctl_t           mem_ctl,
    input  wire logic [SLOT_W-1:0]  rd_addr,
    input  wire logic [SLOT_W-1:0]  wr_addr,
    input  wire logic [INDEX_W-1:0] wr_owner,
    input  wire logic [HASH_W-1:0]  wr_hash,
    output logic      [INDEX_W-1:0] rd_owner
);

    localparam int DEPTH = 1 << SLOT_W;

    logic [INDEX_W-1:0] owner_mem [DEPTH];
    logic [HASH_W-1:0]  hash_mem  [DEPTH];
    logic [INDEX_W-1:0] rd_owner_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_owner_en)
        begin
            owner_mem[wr_addr] <= wr_owner;
        end
        if (mem_ctl.rd_en)
        begin
            rd_owner_reg <= owner_mem[rd_addr];
        end
    end

    // The hash of a claimed slot is kept for lookups done elsewhere.
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_hash_en)
        begin
            hash_mem[wr_addr] <= wr_hash;
        end
    end

    assign rd_owner = rd_owner_reg;

endmodule

`default_nettype wire

/* rtl/hnti_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module hnti_seq
    import hnti_pkg::*;
#(
    parameter int SLOT_W = 11
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               last_byte,
    input  wire logic [INDEX_W-1:0] asset_index,
    input  wire logic [HASH_W-1:0]  mixed_hash,
    input  wire logic [INDEX_W-1:0] rd_owner,
    input  wire logic               out_ready,
    output logic                    in_ready,
    output mem_ctl_t                mem_ctl,
    output logic      [SLOT_W-1:0]  rd_addr,
    output logic      [SLOT_W-1:0]  wr_addr,
    output logic      [INDEX_W-1:0] wr_owner,
    output logic      [HASH_W-1:0]  wr_hash,
    output logic                    out_valid,
    output logic                    insert_status,
    output logic      [POS_W-1:0]   slot_position,
    output logic      [HASH_W-1:0]  final_hash,
    output logic      [COUNT_W-1:0] probe_count
);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [HASH_W-1:0]   h_reg, h_next;
    logic [INDEX_W-1:0]  owner_reg, owner_next;
    logic [SLOT_W-1:0]   sq_reg, sq_next;
    logic [SLOT_W:0]     i_reg, i_next;
    logic [SLOT_W-1:0]   addr_reg, addr_next;
    logic                fail_reg, fail_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_status_reg, out_status_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [HASH_W-1:0]   out_hash_reg, out_hash_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [SLOT_W-1:0]         add_b;
    logic [SLOT_W-1:0]         add_sum;
    logic [SLOT_W:0]           odd_wide;
    logic [SLOT_W:0]           cnt_inc;
    logic [SLOT_W+POS_W-1:0]   pos_wide;
    logic [SLOT_W+COUNT_W:0]   cnt_wide;

    // The one shared adder: probe address (low hash bits plus i*i) in the
    // address step, and the next square (i*i + 2i + 1) in the check step.
    assign odd_wide = {i_reg[SLOT_W-1:0], 1'b1};
    assign add_b    = (state_reg == ST_ADDR) ? h_reg[SLOT_W-1:0] : odd_wide[SLOT_W-1:0];
    assign add_sum  = sq_reg + add_b;
    assign cnt_inc  = i_reg + {{SLOT_W{1'b0}}, 1'b1};
    assign pos_wide = {{POS_W{1'b0}}, addr_reg};
    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_inc};

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        h_next          = h_reg;
        owner_next      = owner_reg;
        sq_next         = sq_reg;
        i_next          = i_reg;
        addr_next       = addr_reg;
        fail_next       = fail_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_hash_next   = out_hash_reg;
        out_cnt_next    = out_cnt_reg;
        mem_ctl         = '0;
        rd_addr         = add_sum;
        wr_addr         = addr_reg;
        wr_owner        = owner_reg;
        wr_hash         = h_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_owner_en = 1'b1;
                wr_addr             = clr_addr_reg;
                wr_owner            = '0;
                clr_addr_next       = clr_addr_reg + {{(SLOT_W-1){1'b0}}, 1'b1};
                if (clr_addr_reg == {SLOT_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && last_byte)
                begin
                    h_next     = mixed_hash;
                    owner_next = asset_index;
                    sq_next    = '0;
                    i_next     = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                mem_ctl.rd_en = 1'b1;
                addr_next     = add_sum;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (rd_owner == '0)
                begin
                    mem_ctl.wr_owner_en = 1'b1;
                    mem_ctl.wr_hash_en  = 1'b1;
                    fail_next           = 1'b0;
                    state_next          = ST_REPORT;
                end
                else if (i_reg[SLOT_W])
                begin
                    // Last allowed probe, i equal to the slot count, was taken.
                    fail_next  = 1'b1;
                    state_next = ST_REPORT;
                end
                else
                begin
                    sq_next    = add_sum;
                    i_next     = cnt_inc;
                    state_next = ST_ADDR;
                end
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fail_reg ? STATUS_FULL : STATUS_CLAIMED;
                    out_pos_next    = fail_reg ? '0 : pos_wide[POS_W-1:0];
                    out_hash_next   = h_reg;
                    out_cnt_next    = cnt_wide[COUNT_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg          <= h_next;
        owner_reg      <= owner_next;
        sq_reg         <= sq_next;
        i_reg          <= i_next;
        addr_reg       <= addr_next;
        fail_reg       <= fail_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_hash_reg   <= out_hash_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign insert_status = out_status_reg;
    assign slot_position = out_pos_reg;
    assign final_hash    = out_hash_reg;
    assign probe_count   = out_cnt_reg;

endmodule

`default_nettype wire

/* rtl/hashed_name_table_insert.sv */
// Hashed name table insert.
// Input channel (in_valid / in_ready) carries one name byte per transfer with
// byte_present, last_byte and asset_index. Bytes are hashed djb2 style at one
// transfer per cycle while in_ready is high. The transfer marked last_byte mixes
// the hash with type_mix and starts a quadratic probe of the slot table.
// Each probe runs an address step and a check step through one shared adder
// and the single read port of the owner store. An insertion holds in_ready low
// through its probes and its report step, which writes its result to the output
// register once that register is free.
// At most TABLE_SLOTS + 1 slots are examined before the failure status.
// The output channel (out_valid / out_ready) is a register: while a result
// waits for the receiver, name bytes of the next name are still taken, and a
// further insertion runs but holds its result until the register is free.
// The config channel (cfg_valid / cfg_ready) writes type_mix; it is always
// ready and must only be used while the block is idle.
// After reset the owner store is cleared one slot per cycle with in_ready low;
// the running hash restarts at 5381.
`timescale 1ns / 1ps
`default_nettype none

module hashed_name_table_insert
    import hnti_pkg::*;
#(
    parameter int TABLE_SLOTS = 2048
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [NAME_W-1:0]  name_byte,
    input  wire logic               byte_present,
    input  wire logic               last_byte,
    input  wire logic [INDEX_W-1:0] asset_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    insert_status,
    output logic      [POS_W-1:0]   slot_position,
    output logic      [HASH_W-1:0]  final_hash,
    output logic      [COUNT_W-1:0] probe_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [HASH_W-1:0]  type_mix
);

    // Slot address width; TABLE_SLOTS must be a power of two.
    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic               in_fire;
    logic               cfg_fire;
    logic [HASH_W-1:0]  mixed_hash;
    mem_ctl_t           mem_ctl;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic [INDEX_W-1:0] wr_owner;
    logic [HASH_W-1:0]  wr_hash;
    logic [INDEX_W-1:0] rd_owner;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // Running name hash and the type mix register.
    hnti_hash u_hash (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .name_byte    (name_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .cfg_fire     (cfg_fire),
        .type_mix     (type_mix),
        .mixed_hash   (mixed_hash)
    );

    // Probe sequencer with the shared address adder and the result register.
    hnti_seq #(
        .SLOT_W (SLOT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .last_byte     (last_byte),
        .asset_index   (asset_index),
        .mixed_hash    (mixed_hash),
        .rd_owner      (rd_owner),
        .out_ready     (out_ready),
        .in_ready      (in_ready),
        .mem_ctl       (mem_ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_owner      (wr_owner),
        .wr_hash       (wr_hash),
        .out_valid     (out_valid),
        .insert_status (insert_status),
        .slot_position (slot_position),
        .final_hash    (final_hash),
        .probe_count   (probe_count)
    );

    // Owner and hash stores of the slot table.
    hnti_slot_mem #(
        .SLOT_W (SLOT_W)
    ) u_mem (
        .clk      (clk),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_owner (wr_owner),
        .wr_hash  (wr_hash),
        .rd_owner (rd_owner)
    );

endmodule

`default_nettype wire

/* rtl/hnti_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module hnti_checker
    import hnti_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               last_byte,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               insert_status,
    input wire logic [POS_W-1:0]   slot_position,
    input wire logic [HASH_W-1:0]  final_hash,
    input wire logic [COUNT_W-1:0] probe_count
);

    // A result that is not taken holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(final_hash)
            && $stable(slot_position) && $stable(probe_count) && $stable(insert_status))
    else $error("stalled result changed");

    // A failed insertion reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (insert_status == STATUS_FULL) |-> slot_position == '0)
    else $error("failed insertion with nonzero slot");

    // The last byte of a name starts a probe, so the input channel closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> !in_ready)
    else $error("input taken during probe");

    // The store is being cleared right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready && !out_valid)
    else $error("ready during clearing pass");

endmodule

bind hashed_name_table_insert hnti_checker u_hnti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .insert_status (insert_status),
    .slot_position (slot_position),
    .final_hash    (final_hash),
    .probe_count   (probe_count)
);

`default_nettype wire

/* tb/hashed_name_table_insert_tb.sv */
`timescale 1ns / 1ps

module hashed_name_table_insert_tb
    import hnti_pkg::*;
;

    localparam int TBL_SLOTS = 2048;
    localparam int SLOT_BITS = $clog2(TBL_SLOTS);
    localparam logic [HASH_W-1:0] SLOT_MASK = TBL_SLOTS - 1;

    // A stuck block is caught by counting cycles in which no channel completes a transfer.
    // The longest correct quiet stretches are a failed insertion, which probes every
    // reachable position and may overlap the long receiver hold-off, and the clearing
    // pass after reset. The limit is several times the larger of these.
    localparam int STALL_LIMIT = 30000;

    // This many cycles let any name bytes still in flight settle before type_mix is written.
    localparam int QUIET_CYCLES = 16;

    // The receiver holds off for this long once, so that the output register fills,
    // a second insertion finishes behind it, and in_ready drops.
    localparam int HOLD_CYCLES = 400;

    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 330;

    // The hammer phase keeps inserting the same hash until this many insertions have
    // run out of probe positions.
    localparam int FULL_WANTED = 3;

    // One name byte, as it is offered on the input channel.
    typedef struct packed {
        logic [NAME_W-1:0]  nbyte;
        logic               present;
        logic               last;
        logic [INDEX_W-1:0] idx;
    } name_item_t;

    // One insertion outcome, as it appears on the output channel.
    typedef struct packed {
        logic               status;
        logic [POS_W-1:0]   pos;
        logic [HASH_W-1:0]  hash;
        logic [COUNT_W-1:0] probes;
    } ins_result_t;

    // One row of the directed table. A row either writes type_mix or offers one
    // name byte. Where the outcome is obvious, the row carries it typed in.
    typedef struct packed {
        logic              is_cfg;
        logic [HASH_W-1:0] cfg_word;
        name_item_t        item;
        logic              typed;
        ins_result_t       want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [NAME_W-1:0]  name_byte;
    logic               byte_present;
    logic               last_byte;
    logic [INDEX_W-1:0] asset_index;
    logic               out_valid;
    logic               out_ready;
    logic               insert_status;
    logic [POS_W-1:0]   slot_position;
    logic [HASH_W-1:0]  final_hash;
    logic [COUNT_W-1:0] probe_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [HASH_W-1:0]  type_mix;

    // The predictor keeps its own copy of the name hash, the slot owners and the
    // mix word.
    logic [HASH_W-1:0]  run_hash;
    logic [INDEX_W-1:0] owner_tab [TBL_SLOTS];
    logic [HASH_W-1:0]  mix_word;

    // Outcomes predicted at input transfers, oldest first.
    ins_result_t claims_due [$];
    ins_result_t got;
    plan_row_t   plan [$];

    int fault_count  = 0;
    int stall_cycles = 0;
    int full_seen    = 0;
    int in_idle_pct  = 9;
    int out_idle_pct = 9;
    bit hold_req     = 1'b0;

    hashed_name_table_insert #(
        .TABLE_SLOTS(TBL_SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .name_byte    (name_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .asset_index  (asset_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .insert_status(insert_status),
        .slot_position(slot_position),
        .final_hash   (final_hash),
        .probe_count  (probe_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .type_mix     (type_mix)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // The predictor. Each present byte folds into the djb2 hash. A last item mixes the
    // hash with the mix word, then walks the quadratic probe sequence until it finds a
    // slot with owner zero or has examined TBL_SLOTS + 1 positions. A zero asset index
    // still claims the slot, but leaves it looking empty to later insertions.
    function automatic bit hash_and_probe(input name_item_t it, output ins_result_t res);
        logic [HASH_W-1:0]    h;
        logic [SLOT_BITS-1:0] spot;
        logic [SLOT_BITS-1:0] claimed;
        int                   i;
        bit                   found;
        res = '0;
        if (it.present)
        begin
            run_hash = run_hash * 32'd33 + {{(HASH_W-NAME_W){1'b0}}, it.nbyte};
        end
        if (!it.last)
        begin
            return 1'b0;
        end
        h        = run_hash ^ mix_word;
        run_hash = HASH_SEED;
        i        = 0;
        found    = 1'b0;
        claimed  = '0;
        while (!found && i <= TBL_SLOTS)
        begin
            spot = SLOT_BITS'((h + HASH_W'(i * i)) & SLOT_MASK);
            i++;
            if (owner_tab[spot] == '0)
            begin
                owner_tab[spot] = it.idx;
                claimed         = spot;
                found           = 1'b1;
            end
        end
        res.status = found ? STATUS_CLAIMED : STATUS_FULL;
        res.pos    = found ? POS_W'(claimed) : '0;
        res.hash   = h;
        res.probes = COUNT_W'(i);
        return 1'b1;
    endfunction

    // Offers one item and returns at the rising edge where it is taken. Idle cycles
    // come first at random, with valid low. Otherwise valid stays high between items.
    task automatic send_item(input name_item_t it, input logic typed, input ins_result_t want);
        ins_result_t res;
        while ($urandom_range(99) < in_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        name_byte    <= it.nbyte;
        byte_present <= it.present;
        last_byte    <= it.last;
        asset_index  <= it.idx;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (hash_and_probe(it, res))
        begin
            claims_due.push_back(typed ? want : res);
            if (res.status == STATUS_FULL)
            begin
                full_seen++;
            end
        end
    endtask

    // Drops valid and waits until every predicted outcome has arrived and any
    // trailing name bytes have been hashed.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (claims_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // type_mix is written only with the block idle.
    task automatic write_mix(input logic [HASH_W-1:0] word);
        wait_quiet();
        @(negedge clk);
        cfg_valid <= 1'b1;
        type_mix  <= word;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        mix_word = word;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic plan_row_t step_row(input logic [NAME_W-1:0] b, input logic p,
                                           input logic l, input logic [INDEX_W-1:0] idx);
        plan_row_t row;
        row            = '0;
        row.item.nbyte = b;
        row.item.present = p;
        row.item.last  = l;
        row.item.idx   = idx;
        return row;
    endfunction

    // An empty name whose outcome is known by hand.
    function automatic plan_row_t checked_row(input logic [INDEX_W-1:0] idx,
                                              input logic [POS_W-1:0] pos,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [COUNT_W-1:0] probes);
        plan_row_t row;
        row             = step_row('0, 1'b0, 1'b1, idx);
        row.typed       = 1'b1;
        row.want.status = STATUS_CLAIMED;
        row.want.pos    = pos;
        row.want.hash   = hash;
        row.want.probes = probes;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [HASH_W-1:0] word);
        plan_row_t row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.cfg_word = word;
        return row;
    endfunction

    // Every outcome that leaves the block is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (claims_due.size() == 0)
            begin
                $error("insert outcome with none predicted: slot %0d hash %h",
                       slot_position, final_hash);
                fault_count++;
            end
            else
            begin
                got = claims_due.pop_front();
                if (insert_status !== got.status)
                begin
                    $error("insert_status: expected %0d, got %0d", got.status, insert_status);
                    fault_count++;
                end
                if (slot_position !== got.pos)
                begin
                    $error("slot_position: expected %0d, got %0d", got.pos, slot_position);
                    fault_count++;
                end
                if (final_hash !== got.hash)
                begin
                    $error("final_hash: expected %h, got %h", got.hash, final_hash);
                    fault_count++;
                end
                if (probe_count !== got.probes)
                begin
                    $error("probe_count: expected %0d, got %0d", got.probes, probe_count);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver. It stalls at random, and once, on request, holds off for a long
    // stretch that it counts itself.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    initial
    begin
        name_item_t it;
        int         phase;
        int         sent;
        int         len;
        int         k;
        int         pick;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        name_byte    = '0;
        byte_present = 1'b0;
        last_byte    = 1'b0;
        asset_index  = '0;
        cfg_valid    = 1'b0;
        type_mix     = '0;

        run_hash = HASH_SEED;
        mix_word = MIX_RESET;
        foreach (owner_tab[s])
        begin
            owner_tab[s] = '0;
        end

        // Empty names right after reset with the reset mix give
        // 5381 ^ 0xcb03f267 = 0xcb03e762, so probing starts at slot 0x762 and steps
        // by 0, 1, 4, 9. The zero asset index claims 0x766 but leaves it empty, so the
        // next insertion claims it again. Then the mix word goes to both extremes,
        // where the hash becomes 5381 itself and its complement.
        plan.push_back(checked_row(16'h0001, 11'h762, 32'hcb03e762, 12'd1));
        plan.push_back(checked_row(16'hffff, 11'h763, 32'hcb03e762, 12'd2));
        plan.push_back(checked_row(16'h0000, 11'h766, 32'hcb03e762, 12'd3));
        plan.push_back(checked_row(16'h0005, 11'h766, 32'hcb03e762, 12'd3));
        plan.push_back(cfg_row(32'h0000_0000));
        plan.push_back(checked_row(16'h0002, 11'h505, 32'h0000_1505, 12'd1));
        plan.push_back(cfg_row(32'hffff_ffff));
        plan.push_back(checked_row(16'h0003, 11'h2fa, 32'hffff_eafa, 12'd1));
        plan.push_back(cfg_row(MIX_RESET));
        // Byte extremes in the middle of a name, a skipped byte, and a present last
        // byte. Asset index on non-last items is junk and must be ignored.
        plan.push_back(step_row(8'h00, 1'b1, 1'b0, 16'hffff));
        plan.push_back(step_row(8'hff, 1'b1, 1'b0, 16'h0000));
        plan.push_back(step_row(8'ha5, 1'b0, 1'b0, 16'h1234));
        plan.push_back(step_row(8'h80, 1'b1, 1'b1, 16'h1234));
        // One-byte names at both extremes.
        plan.push_back(step_row(8'hff, 1'b1, 1'b1, 16'h00ff));
        plan.push_back(step_row(8'h00, 1'b1, 1'b1, 16'hff00));
        // A name closed by an item that carries no byte.
        plan.push_back(step_row(8'h61, 1'b1, 1'b0, 16'h0000));
        plan.push_back(step_row(8'h62, 1'b1, 1'b0, 16'h0000));
        plan.push_back(step_row(8'h77, 1'b0, 1'b1, 16'h0007));
        // The hand-checked empty name again, now one step further along its probes.
        plan.push_back(step_row(8'h00, 1'b0, 1'b1, 16'h0009));
        plan.push_back(step_row(8'h5a, 1'b1, 1'b1, 16'h8001));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
            begin
                write_mix(plan[r].cfg_word);
            end
            else
            begin
                send_item(plan[r].item, plan[r].typed, plan[r].want);
            end
        end

        // Hammer one hash with empty names until every slot its probe sequence can
        // reach is owned. Each insertion probes further than the last, and the final
        // ones exhaust all TBL_SLOTS + 1 positions and report the table full.
        write_mix($urandom);
        full_seen = 0;
        while (full_seen < FULL_WANTED)
        begin
            it.nbyte   = 8'($urandom_range(255));
            it.present = 1'b0;
            it.last    = 1'b1;
            it.idx     = 16'($urandom_range(65535, 1));
            send_item(it, 1'b0, '0);
        end

        // Random names under several mix words. The first phase starts with the long
        // receiver hold-off, and the third runs with no idling on either side.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_mix($urandom);
            if (phase == 0)
            begin
                hold_req = 1'b1;
            end
            in_idle_pct  = (phase == 2) ? 0 : 9;
            out_idle_pct = (phase == 2) ? 0 : 9;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                begin
                    it.nbyte   = 8'($urandom_range(255));
                    it.last    = (k == len - 1);
                    it.present = it.last ? ($urandom_range(4) != 0) : ($urandom_range(9) != 0);
                    pick       = $urandom_range(99);
                    if (!it.last)
                    begin
                        it.idx = 16'($urandom_range(65535));
                    end
                    else if (pick < 3)
                    begin
                        it.idx = '0;
                    end
                    else if (pick < 6)
                    begin
                        it.idx = 16'hffff;
                    end
                    else
                    begin
                        it.idx = 16'($urandom_range(65535, 1));
                    end
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end
        end

        in_idle_pct  = 9;
        out_idle_pct = 9;
        wait_quiet();
        if (fault_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* hashed_name_table_insert.f */
rtl/hnti_pkg.sv
rtl/hnti_hash.sv
rtl/hnti_slot_mem.sv
rtl/hnti_seq.sv
rtl/hashed_name_table_insert.sv
rtl/hnti_checker.sv
tb/hashed_name_table_insert_tb.sv
